// ===== rtl/at_rsp_pkg.sv =====
// at_rsp_pkg: state codes, character codes and verdict codes for the
// AT response parser; no dependencies

package at_rsp_pkg;

    // parser states, one-hot
    typedef enum logic [17:0] {
        S_START    = 18'h00001,  // expecting first CR
        S_LF0      = 18'h00002,  // expecting first LF
        S_BODY     = 18'h00004,  // expecting O, E or +
        S_K        = 18'h00008,  // after O, expecting K
        S_CR_END   = 18'h00010,  // after OK / ERROR, expecting CR
        S_LF_END   = 18'h00020,  // expecting final LF
        S_ACCEPT   = 18'h00040,  // response accepted
        S_ER1      = 18'h00080,  // after E
        S_ER2      = 18'h00100,  // after ER
        S_ER3      = 18'h00200,  // after ERR
        S_ER4      = 18'h00400,  // after ERRO
        S_TXT_HEAD = 18'h00800,  // after +, first text char
        S_TXT      = 18'h01000,  // inside text line
        S_TXT_LF   = 18'h02000,  // after text CR
        S_TXT_NEXT = 18'h04000,  // after text line, expecting + or CR
        S_BLANK_LF = 18'h08000,  // blank line LF
        S_FINAL    = 18'h10000,  // expecting O or E after blank line
        S_FAIL     = 18'h20000   // response malformed
    } parse_state_t;

    // verdict codes
    typedef enum logic [1:0] {
        V_RUNNING = 2'd0,
        V_ACCEPT  = 2'd1,
        V_FAIL    = 2'd2
    } verdict_t;

    // character codes
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_O    = 8'h4F;
    localparam logic [7:0] CH_K    = 8'h4B;
    localparam logic [7:0] CH_E    = 8'h45;
    localparam logic [7:0] CH_R    = 8'h52;
    localparam logic [7:0] CH_PLUS = 8'h2B;

endpackage

// ===== rtl/at_response_parser_core.sv =====
// at_response_parser_core: checks a modem AT response one character per item
// depends on at_rsp_pkg
//
// pipeline: input register, then result register
// throughput: one item per cycle unless m_axis_tready stalls the result
// reset: rst_n clears state, column, line count and both valid flags

module at_response_parser_core #(
    parameter int MAX_LINES = 16,
    parameter int MAX_COLS  = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_in
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [1:0] verdict, [2] store_valid,
                                       // [6:3] store_line, [14:7] store_col,
                                       // [15] zero fill
    output logic       m_axis_tlast    // line_done
);
    import at_rsp_pkg::*;

    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam logic [LINE_W-1:0] LINE_LAST = LINE_W'(MAX_LINES - 1);
    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAX_COLS - 1);

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;

    // parser state
    parse_state_t      state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;

    // result register
    logic        out_valid_reg;
    logic [15:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;

    logic advance;
    logic out_free;

    // handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // transition logic
    verdict_t verdict;
    logic     stored;
    logic     eol;
    logic     keep;
    logic [LINE_W+3:0] line_ext;

    always_comb
    begin
        state_next = S_FAIL;
        verdict    = V_RUNNING;
        stored     = 1'b1;
        eol        = 1'b0;
        unique case (state_reg)
            S_START:    if (in_char_reg == CH_CR) state_next = S_LF0;
            S_LF0:
            begin
                if (in_char_reg == CH_LF)
                begin
                    state_next = S_BODY;
                    eol        = 1'b1;
                end
            end
            S_BODY:
            begin
                if (in_char_reg == CH_O)         state_next = S_K;
                else if (in_char_reg == CH_E)    state_next = S_ER1;
                else if (in_char_reg == CH_PLUS) state_next = S_TXT_HEAD;
            end
            S_K:        if (in_char_reg == CH_K)  state_next = S_CR_END;
            S_CR_END:   if (in_char_reg == CH_CR) state_next = S_LF_END;
            S_LF_END:
            begin
                if (in_char_reg == CH_LF)
                begin
                    state_next = S_ACCEPT;
                    eol        = 1'b1;
                end
            end
            S_ER1:      if (in_char_reg == CH_R) state_next = S_ER2;
            S_ER2:      if (in_char_reg == CH_R) state_next = S_ER3;
            S_ER3:      if (in_char_reg == CH_O) state_next = S_ER4;
            S_ER4:      if (in_char_reg == CH_R) state_next = S_CR_END;
            S_TXT_HEAD: if (in_char_reg != CH_CR) state_next = S_TXT;
            S_TXT:      state_next = (in_char_reg == CH_CR) ? S_TXT_LF : S_TXT;
            S_TXT_LF:
            begin
                if (in_char_reg == CH_LF)
                begin
                    state_next = S_TXT_NEXT;
                    eol        = 1'b1;
                end
            end
            S_TXT_NEXT:
            begin
                if (in_char_reg == CH_CR)        state_next = S_BLANK_LF;
                else if (in_char_reg == CH_PLUS) state_next = S_TXT_HEAD;
            end
            S_BLANK_LF:
            begin
                if (in_char_reg == CH_LF)
                begin
                    state_next = S_FINAL;
                    eol        = 1'b1;
                end
            end
            S_FINAL:
            begin
                if (in_char_reg == CH_O)      state_next = S_K;
                else if (in_char_reg == CH_E) state_next = S_ER1;
            end
            S_ACCEPT:
            begin
                state_next = S_ACCEPT;
                verdict    = V_ACCEPT;
                stored     = 1'b0;
            end
            default:
            begin
                state_next = S_FAIL;
                verdict    = V_FAIL;
                stored     = 1'b0;
            end
        endcase

        // the rejecting character is not stored
        keep = stored && !(verdict == V_RUNNING && state_next == S_FAIL);

        // position bookkeeping
        col_next  = col_reg;
        line_next = line_reg;
        if (keep)
        begin
            if (eol)
            begin
                col_next = '0;
                if (line_reg < LINE_LAST) line_next = line_reg + 1'b1;
            end
            else if (col_reg < COL_LAST)
            begin
                col_next = col_reg + 1'b1;
            end
        end

        // result packing
        line_ext      = {4'b0000, line_reg};
        out_data_next = '0;
        out_data_next[1:0] = verdict;
        out_data_next[2]   = keep;
        if (keep)
        begin
            out_data_next[6:3]  = line_ext[3:0];
            out_data_next[14:7] = 8'(col_reg);
        end
        out_last_next = keep && eol;
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= S_START;
            col_reg       <= '0;
            line_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready) in_valid_reg <= s_axis_tvalid;
            if (out_free)      out_valid_reg <= in_valid_reg;
            if (advance)
            begin
                state_reg <= state_next;
                col_reg   <= col_next;
                line_reg  <= line_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) in_char_reg <= s_axis_tdata;
        if (advance)
        begin
            out_data_reg <= out_data_next;
            out_last_reg <= out_last_next;
        end
    end

    // checks
    a_last_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[2])
        else $error("line end reported for an item that was not stored");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[2]) |-> (m_axis_tdata[14:3] == 12'd0))
        else $error("position reported for an item that was not stored");

    a_verdict_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != V_RUNNING) |-> !m_axis_tdata[2])
        else $error("item stored after a final verdict");

    a_accept_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] == V_ACCEPT) |-> state_reg == S_ACCEPT)
        else $error("accept verdict without the accept state");

    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg == S_FAIL) |=> state_reg == S_FAIL)
        else $error("parser left the fail state");

endmodule

// ===== tb/at_response_parser_core_tb.sv =====
// at_response_parser_core_tb: self-checking bench for the AT response parser,
// one long response with random text lines, checked item by item
// depends on at_rsp_pkg and at_response_parser_core
`timescale 1ns / 1ps

module at_response_parser_core_tb;

    import at_rsp_pkg::*;

    localparam int MAX_LINES = 16;
    localparam int MAX_COLS  = 256;
    localparam int RANDOM_ITEMS = 1560;
    localparam int LONG_HOLD = 300;

    // one result item, in field order
    typedef struct packed {
        verdict_t   verdict;
        logic       store_valid;
        logic [3:0] store_line;
        logic [7:0] store_col;
        logic       line_done;
    } parse_result_t;

    typedef struct packed {
        logic [7:0]    ch;
        logic          typed;
        parse_result_t res;
    } stim_row_t;

    localparam parse_result_t NO_CHECK = '{V_RUNNING, 1'b0, 4'd0, 8'd0, 1'b0};

    // opening of the response; typed rows carry their result, the rest go to the predictor
    localparam stim_row_t OPENING [20] = '{
        '{CH_CR,   1'b1, '{V_RUNNING, 1'b1, 4'd0, 8'd0, 1'b0}},  // first item after reset
        '{CH_LF,   1'b1, '{V_RUNNING, 1'b1, 4'd0, 8'd1, 1'b1}},  // header line ends
        '{CH_PLUS, 1'b1, '{V_RUNNING, 1'b1, 4'd1, 8'd0, 1'b0}},
        '{8'hFF,   1'b1, '{V_RUNNING, 1'b1, 4'd1, 8'd1, 1'b0}},  // top code as text
        '{8'h00,   1'b1, '{V_RUNNING, 1'b1, 4'd1, 8'd2, 1'b0}},  // bottom code as text
        '{CH_LF,   1'b1, '{V_RUNNING, 1'b1, 4'd1, 8'd3, 1'b0}},  // text lf, line goes on
        '{CH_O,    1'b0, NO_CHECK},
        '{CH_K,    1'b0, NO_CHECK},
        '{CH_E,    1'b0, NO_CHECK},
        '{CH_R,    1'b0, NO_CHECK},
        '{8'h7F,   1'b0, NO_CHECK},
        '{8'h80,   1'b0, NO_CHECK},
        '{8'h55,   1'b0, NO_CHECK},
        '{8'hAA,   1'b0, NO_CHECK},
        '{CH_CR,   1'b0, NO_CHECK},
        '{CH_LF,   1'b0, NO_CHECK},
        '{CH_PLUS, 1'b0, NO_CHECK},  // second text line, one char long
        '{8'h01,   1'b0, NO_CHECK},
        '{CH_CR,   1'b0, NO_CHECK},
        '{CH_LF,   1'b0, NO_CHECK}
    };

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    // predictor state
    parse_state_t resp_state;
    logic [7:0]   col_pos;
    logic [3:0]   line_idx;

    parse_result_t expected_results[$];
    int unsigned   items_sent;
    int unsigned   results_checked;
    int unsigned   lines_closed;
    int unsigned   mismatches;
    int unsigned   burst_left;
    int unsigned   hold_cnt;
    logic [1:0]    last_verdict;

    at_response_parser_core #(
        .MAX_LINES(MAX_LINES),
        .MAX_COLS (MAX_COLS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // safety net
    initial
    begin
        #2_000_000;
        $display("at_response_parser_core_tb NOT OK");
        $finish;
    end

    // next parser state and stored position for one character
    function automatic parse_result_t parse_char(input logic [7:0] c);
        parse_state_t  nxt;
        parse_result_t r;
        logic          eol;
        nxt = S_FAIL;
        eol = 1'b0;
        r   = '{V_RUNNING, 1'b1, 4'd0, 8'd0, 1'b0};
        case (resp_state)
            S_START:    if (c == CH_CR) nxt = S_LF0;
            S_LF0:      if (c == CH_LF) begin nxt = S_BODY; eol = 1'b1; end
            S_BODY:
            begin
                if (c == CH_O) nxt = S_K;
                else if (c == CH_E) nxt = S_ER1;
                else if (c == CH_PLUS) nxt = S_TXT_HEAD;
            end
            S_K:        if (c == CH_K) nxt = S_CR_END;
            S_CR_END:   if (c == CH_CR) nxt = S_LF_END;
            S_LF_END:   if (c == CH_LF) begin nxt = S_ACCEPT; eol = 1'b1; end
            S_ER1:      if (c == CH_R) nxt = S_ER2;
            S_ER2:      if (c == CH_R) nxt = S_ER3;
            S_ER3:      if (c == CH_O) nxt = S_ER4;
            S_ER4:      if (c == CH_R) nxt = S_CR_END;
            S_TXT_HEAD: if (c != CH_CR) nxt = S_TXT;
            S_TXT:      nxt = (c == CH_CR) ? S_TXT_LF : S_TXT;
            S_TXT_LF:   if (c == CH_LF) begin nxt = S_TXT_NEXT; eol = 1'b1; end
            S_TXT_NEXT:
            begin
                if (c == CH_CR) nxt = S_BLANK_LF;
                else if (c == CH_PLUS) nxt = S_TXT_HEAD;
            end
            S_BLANK_LF: if (c == CH_LF) begin nxt = S_FINAL; eol = 1'b1; end
            S_FINAL:
            begin
                if (c == CH_O) nxt = S_K;
                else if (c == CH_E) nxt = S_ER1;
            end
            S_ACCEPT:
            begin
                nxt = S_ACCEPT;
                r.verdict = V_ACCEPT;
                r.store_valid = 1'b0;
            end
            default:
            begin
                nxt = S_FAIL;
                r.verdict = V_FAIL;
                r.store_valid = 1'b0;
            end
        endcase
        // the rejecting character itself is not stored
        if (r.verdict == V_RUNNING && nxt == S_FAIL)
            r.store_valid = 1'b0;
        if (r.store_valid)
        begin
            r.store_line = line_idx;
            r.store_col  = col_pos;
            r.line_done  = eol;
            if (int'(col_pos) < MAX_COLS - 1)
                col_pos = col_pos + 8'd1;
            if (eol)
            begin
                col_pos = 8'd0;
                if (int'(line_idx) < MAX_LINES - 1)
                    line_idx = line_idx + 4'd1;
            end
        end
        resp_state = nxt;
        return r;
    endfunction

    // offer one item, called at a falling edge, returns at a falling edge
    task automatic offer_char(input logic [7:0] c, input logic typed,
                              input parse_result_t typed_res);
        parse_result_t r;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        r = parse_char(c);
        expected_results.push_back(typed ? typed_res : r);
        items_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // stop offering until every result is back
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // '+' line with random text, then cr lf
    task automatic send_text_line(input int unsigned len);
        logic [7:0]  c;
        int unsigned i;
        offer_char(CH_PLUS, 1'b0, NO_CHECK);
        for (i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 15))
                0:       c = CH_LF;
                1:       c = CH_PLUS;
                2:       c = CH_O;
                3:       c = CH_K;
                4:       c = CH_E;
                5:       c = CH_R;
                default: c = 8'($urandom_range(0, 255));
            endcase
            // cr would close the line early
            if (c == CH_CR)
                c = CH_LF;
            offer_char(c, 1'b0, NO_CHECK);
        end
        offer_char(CH_CR, 1'b0, NO_CHECK);
        offer_char(CH_LF, 1'b0, NO_CHECK);
    endtask

    // blank line and final status, intact or with one bad character
    task automatic send_closing();
        logic [7:0]  tail [$];
        logic [7:0]  c;
        int unsigned bad_pos;
        int unsigned i;
        offer_char(CH_CR, 1'b0, NO_CHECK);
        offer_char(CH_LF, 1'b0, NO_CHECK);
        if ($urandom_range(0, 1) == 0)
            tail = '{CH_O, CH_K, CH_CR, CH_LF};
        else
            tail = '{CH_E, CH_R, CH_R, CH_O, CH_R, CH_CR, CH_LF};
        bad_pos = ($urandom_range(0, 1) == 0) ? tail.size()
                                               : $urandom_range(0, tail.size() - 1);
        for (i = 0; i < tail.size(); i++)
        begin
            c = tail[i];
            if (i == bad_pos)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == tail[i])
                    c = ~c;
            end
            offer_char(c, 1'b0, NO_CHECK);
        end
        // after the verdict every item is ignored
        repeat (12) offer_char(8'($urandom_range(0, 255)), 1'b0, NO_CHECK);
    endtask

    // field compare
    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin : result_check
        parse_result_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no expectation: tdata %h", m_axis_tdata);
                mismatches++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                check_field("verdict", 8'(exp_r.verdict), 8'(m_axis_tdata[1:0]));
                check_field("store_valid", 8'(exp_r.store_valid), 8'(m_axis_tdata[2]));
                check_field("store_line", 8'(exp_r.store_line), 8'(m_axis_tdata[6:3]));
                check_field("store_col", exp_r.store_col, m_axis_tdata[14:7]);
                check_field("line_done", 8'(exp_r.line_done), 8'(m_axis_tlast));
                results_checked++;
                if (m_axis_tlast === 1'b1)
                    lines_closed++;
                last_verdict = m_axis_tdata[1:0];
            end
        end
    end

    // receiver stalls: long hold on request, otherwise changing patterns
    initial
    begin : receiver
        int unsigned pattern_left;
        int unsigned stall_mode;
        int unsigned phase;
        m_axis_tready = 1'b0;
        pattern_left = 0;
        stall_mode = 0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase++;
            if (hold_cnt != 0)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                case (stall_mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (phase % 5 != 2);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned row;
        int unsigned long_at;
        int unsigned lines_sent;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        resp_state = S_START;
        col_pos = 8'd0;
        line_idx = 4'd0;
        items_sent = 0;
        results_checked = 0;
        lines_closed = 0;
        mismatches = 0;
        burst_left = 0;
        hold_cnt = 0;
        last_verdict = 2'd0;
        lines_sent = 0;
        long_at = $urandom_range(3, 30);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (row = 0; row < $size(OPENING); row++)
            offer_char(OPENING[row].ch, OPENING[row].typed, OPENING[row].res);

        // text lines; the response stays well formed so parsing never ends early
        while (items_sent < RANDOM_ITEMS)
        begin
            if (lines_sent == long_at)
                send_text_line($urandom_range(260, 320));  // column runs into its limit
            else if ($urandom_range(0, 7) == 0)
                send_text_line($urandom_range(25, 60));
            else
                send_text_line($urandom_range(1, 12));
            lines_sent++;
            if (lines_sent == 20)
            begin
                burst_left = 200;
                hold_cnt = LONG_HOLD;
            end
            if (lines_sent == 60)
                wait_idle();
        end

        send_closing();

        // drain and look for stray results
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d items in %0d text lines, checked %0d results, %0d line ends",
                 items_sent, lines_sent, results_checked, lines_closed);
        $display("final verdict code %0d (1 accepted, 2 malformed)", last_verdict);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("at_response_parser_core_tb OK");
        else
            $display("at_response_parser_core_tb NOT OK");
        $finish;
    end

endmodule
